// ===== hdl/ir_temp_qualify_average_alert_defines.svh =====
// assertion macros for the ir thermometer qualifier block
// used by the checker module, expects clk and arst_n in scope
`ifndef IR_TEMP_QUALIFY_AVERAGE_ALERT_DEFINES_SVH
`define IR_TEMP_QUALIFY_AVERAGE_ALERT_DEFINES_SVH

// same-cycle implication
`define IRTQ_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IRTQ_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/irtq_pkg.sv =====
// shared types and constants for the ir thermometer qualifier block
// no dependencies
package irtq_pkg;

	localparam int TempW  = 15;
	localparam int RawW   = 16;
	localparam int StampW = 32;
	localparam int CfgW   = 32;
	localparam int CfgAddrW = 3;

	localparam int BURST_SAMPLES_DEF = 8;

	localparam logic [TempW-1:0]  WARN_LEVEL_RST  = 15'd16658;
	localparam logic [TempW-1:0]  CLEAR_LEVEL_RST = 15'd16408;
	localparam logic [StampW-1:0] COOLDOWN_RST    = 32'd60000;
	localparam logic [TempW-1:0]  MIN_VALID_RST   = 15'd11658;
	localparam logic [TempW-1:0]  MAX_VALID_RST   = 15'd32657;

	typedef enum logic [CfgAddrW-1:0] {
		CFG_WARN_LEVEL  = 3'd0,
		CFG_CLEAR_LEVEL = 3'd1,
		CFG_COOLDOWN    = 3'd2,
		CFG_MIN_VALID   = 3'd3,
		CFG_MAX_VALID   = 3'd4
	} cfg_idx_t;

	typedef enum logic {
		CMD_SAMPLE = 1'b0,
		CMD_BURST  = 1'b1
	} cmd_t;

	typedef struct packed {
		logic              command;
		logic [RawW-1:0]   raw_object;
		logic [RawW-1:0]   raw_ambient;
		logic [StampW-1:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [TempW-1:0] object_temp;
		logic [TempW-1:0] ambient_temp;
		logic             has_data;
		logic             sample_rejected;
		logic             warn_event;
		logic             normal_event;
		logic             alert_on;
		logic             burst_busy;
		logic             burst_done;
	} out_item_t;

	typedef struct packed {
		logic             busy;
		logic             busy_next;
		logic             done;
		logic [TempW-1:0] avg;
	} burst_stat_t;

	typedef struct packed {
		logic warn;
		logic normal;
		logic active_next;
	} alert_stat_t;

endpackage

// ===== hdl/irtq_word_check.sv =====
// error flag and plausible range check of one raw thermometer word
// depends on irtq_pkg
module irtq_word_check (
	input  logic [irtq_pkg::RawW-1:0]  raw,
	input  logic [irtq_pkg::TempW-1:0] min_valid,
	input  logic [irtq_pkg::TempW-1:0] max_valid,
	output logic                       ok,
	output logic [irtq_pkg::TempW-1:0] value
);
	import irtq_pkg::*;

	assign value = raw[TempW-1:0];
	assign ok = !raw[RawW-1] && (value >= min_valid) && (value <= max_valid);

endmodule

// ===== hdl/irtq_burst_avg.sv =====
// burst accumulator and rounded average by reciprocal multiply
// depends on irtq_pkg
module irtq_burst_avg #(
	parameter int BurstSamples = irtq_pkg::BURST_SAMPLES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic                       command,
	input  logic                       obj_ok,
	input  logic [irtq_pkg::TempW-1:0] obj_val,
	output irtq_pkg::burst_stat_t      stat
);
	import irtq_pkg::*;

	localparam int Lg      = $clog2(BurstSamples);
	localparam int CntW    = (BurstSamples > 1) ? Lg : 1;
	localparam int SumW    = TempW + Lg;
	localparam int Shift   = SumW + Lg;
	localparam int RecipW  = SumW + 1;
	localparam int ProdW   = SumW + RecipW;
	localparam logic [RecipW-1:0] Recip = RecipW'(((longint'(1) << Shift)
		+ longint'(BurstSamples) - 1) / longint'(BurstSamples));
	localparam logic [SumW-1:0] Half = SumW'(BurstSamples / 2);

	logic            running_q;
	logic [CntW-1:0] count_q;
	logic [SumW-1:0] sum_q;

	logic             is_sample;
	logic             last;
	logic [SumW-1:0]  sum_add;
	logic [SumW-1:0]  round_sum;
	logic [ProdW-1:0] prod;

	assign is_sample = (command == CMD_SAMPLE) && running_q;
	assign last      = (count_q == CntW'(BurstSamples - 1));
	assign sum_add   = sum_q + SumW'(obj_val);
	assign round_sum = sum_add + Half;
	assign prod      = ProdW'(round_sum) * ProdW'(Recip);

	always_comb begin
		stat.busy      = running_q;
		stat.done      = is_sample && obj_ok && last;
		stat.avg       = prod[Shift +: TempW];
		stat.busy_next = running_q ? !stat.done : (command == CMD_BURST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			count_q   <= '0;
			sum_q     <= '0;
		end else if (accept) begin
			if (command == CMD_BURST) begin
				if (!running_q) begin
					running_q <= 1'b1;
					count_q   <= '0;
					sum_q     <= '0;
				end
			end else if (running_q && obj_ok) begin
				if (last) begin
					running_q <= 1'b0;
					count_q   <= '0;
					sum_q     <= '0;
				end else begin
					count_q <= count_q + 1'b1;
					sum_q   <= sum_add;
				end
			end
		end
	end

endmodule

// ===== hdl/irtq_alert.sv =====
// hysteresis alarm with cooldown on a wrapping millisecond stamp
// depends on irtq_pkg
module irtq_alert (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic                        check,
	input  logic [irtq_pkg::TempW-1:0]  obj_val,
	input  logic [irtq_pkg::StampW-1:0] now_ms,
	input  logic [irtq_pkg::TempW-1:0]  warn_level,
	input  logic [irtq_pkg::TempW-1:0]  clear_level,
	input  logic [irtq_pkg::StampW-1:0] rearm_ms,
	output irtq_pkg::alert_stat_t       stat
);
	import irtq_pkg::*;

	logic              active_q;
	logic [StampW-1:0] stamp_q;
	logic [StampW-1:0] elapsed;
	logic              hot;
	logic              cold;

	assign elapsed = now_ms - stamp_q;
	assign hot     = obj_val >= warn_level;
	assign cold    = obj_val < clear_level;

	always_comb begin
		stat.warn        = check && hot && (!active_q || (elapsed >= rearm_ms));
		stat.normal      = check && !hot && cold && active_q;
		stat.active_next = stat.warn ? 1'b1 : (stat.normal ? 1'b0 : active_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			stamp_q  <= '0;
		end else if (accept) begin
			active_q <= stat.active_next;
			if (stat.warn) begin
				stamp_q <= now_ms;
			end else if (stat.normal) begin
				stamp_q <= '0;
			end
		end
	end

endmodule

// ===== hdl/ir_temp_qualify_average_alert.sv =====
// ir thermometer sample qualifier, burst averager and hysteresis alarm
// depends on irtq_pkg, irtq_word_check, irtq_burst_avg, irtq_alert
//
// usage:
// in_valid/in_ready carry one item: a raw object/ambient word pair with a
// millisecond stamp, or a burst request. every accepted item gives exactly
// one result on out_valid/out_ready.
// the result of an accepted item is registered and shown in the next cycle.
// throughput is one item per cycle while the receiver takes results; all
// qualification, averaging and alarm logic sits between the input
// handshake and the single output register.
// when the receiver stalls, the result stays in the output register and
// in_ready drops until it is taken; a new item is taken in the same cycle
// the waiting result leaves.
// the configuration port writes a register at any edge with cfg_we high.
// reset clears the stored temperatures, the alarm, the burst and the output
// valid flag, and loads the default levels.
module ir_temp_qualify_average_alert #(
	parameter int BurstSamples = irtq_pkg::BURST_SAMPLES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [irtq_pkg::CfgAddrW-1:0] cfg_addr,
	input  logic [irtq_pkg::CfgW-1:0]     cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  irtq_pkg::in_item_t            in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output irtq_pkg::out_item_t           out_data
);
	import irtq_pkg::*;

	logic [TempW-1:0]  warn_level_q;
	logic [TempW-1:0]  clear_level_q;
	logic [StampW-1:0] cooldown_q;
	logic [TempW-1:0]  min_valid_q;
	logic [TempW-1:0]  max_valid_q;

	logic [TempW-1:0] object_q;
	logic [TempW-1:0] ambient_q;
	logic             seen_q;
	logic             out_valid_q;
	out_item_t        out_q;

	logic             accept;
	logic             obj_ok;
	logic             amb_ok;
	logic [TempW-1:0] obj_val;
	logic [TempW-1:0] amb_val;
	logic             plain;
	logic             store;
	logic             rejected;
	logic             check;
	logic [TempW-1:0] object_next;
	logic [TempW-1:0] ambient_next;
	logic             seen_next;
	burst_stat_t      burst;
	alert_stat_t      alert;

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warn_level_q  <= WARN_LEVEL_RST;
			clear_level_q <= CLEAR_LEVEL_RST;
			cooldown_q    <= COOLDOWN_RST;
			min_valid_q   <= MIN_VALID_RST;
			max_valid_q   <= MAX_VALID_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_addr))
				CFG_WARN_LEVEL:  warn_level_q  <= cfg_wdata[TempW-1:0];
				CFG_CLEAR_LEVEL: clear_level_q <= cfg_wdata[TempW-1:0];
				CFG_COOLDOWN:    cooldown_q    <= cfg_wdata[StampW-1:0];
				CFG_MIN_VALID:   min_valid_q   <= cfg_wdata[TempW-1:0];
				CFG_MAX_VALID:   max_valid_q   <= cfg_wdata[TempW-1:0];
				default: ;
			endcase
		end
	end

	irtq_word_check u_obj_chk (
		.raw       (in_data.raw_object),
		.min_valid (min_valid_q),
		.max_valid (max_valid_q),
		.ok        (obj_ok),
		.value     (obj_val)
	);

	irtq_word_check u_amb_chk (
		.raw       (in_data.raw_ambient),
		.min_valid (min_valid_q),
		.max_valid (max_valid_q),
		.ok        (amb_ok),
		.value     (amb_val)
	);

	irtq_burst_avg #(
		.BurstSamples (BurstSamples)
	) u_burst (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.command (in_data.command),
		.obj_ok  (obj_ok),
		.obj_val (obj_val),
		.stat    (burst)
	);

	always_comb begin
		plain    = (in_data.command == CMD_SAMPLE) && !burst.busy;
		store    = plain && obj_ok && amb_ok;
		rejected = (in_data.command == CMD_SAMPLE)
			&& (burst.busy ? !obj_ok : !(obj_ok && amb_ok));
		check    = store || burst.done;
		object_next  = store ? obj_val : (burst.done ? burst.avg : object_q);
		ambient_next = store ? amb_val : ambient_q;
		seen_next    = seen_q || check;
	end

	irtq_alert u_alert (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.check       (check),
		.obj_val     (object_next),
		.now_ms      (in_data.now_ms),
		.warn_level  (warn_level_q),
		.clear_level (clear_level_q),
		.rearm_ms    (cooldown_q),
		.stat        (alert)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			object_q    <= '0;
			ambient_q   <= '0;
			seen_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				object_q    <= object_next;
				ambient_q   <= ambient_next;
				seen_q      <= seen_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			out_q.object_temp     <= object_next;
			out_q.ambient_temp    <= ambient_next;
			out_q.has_data        <= seen_next;
			out_q.sample_rejected <= rejected;
			out_q.warn_event      <= alert.warn;
			out_q.normal_event    <= alert.normal;
			out_q.alert_on        <= alert.active_next;
			out_q.burst_busy      <= burst.busy_next;
			out_q.burst_done      <= burst.done;
		end
	end

endmodule

// ===== hdl/irtq_checker.sv =====
// port level checks for the ir thermometer qualifier block, bound to the top
// depends on irtq_pkg and ir_temp_qualify_average_alert_defines.svh
`include "ir_temp_qualify_average_alert_defines.svh"

module irtq_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input irtq_pkg::out_item_t out_data
);
	import irtq_pkg::*;

	`IRTQ_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")
	`IRTQ_ASSERT_IMP(a_ready_empty, !out_valid, in_ready, "input stalled with empty output")
	`IRTQ_ASSERT_IMP(a_events_excl, out_valid, !(out_data.warn_event && out_data.normal_event), "warn and normal on one item")
	`IRTQ_ASSERT_IMP(a_done_state, out_valid && out_data.burst_done, !out_data.burst_busy && out_data.has_data, "burst done with busy or no data")
	`IRTQ_ASSERT_IMP(a_event_alert, out_valid && (out_data.warn_event || out_data.normal_event), out_data.alert_on == out_data.warn_event, "alert state disagrees with event")

endmodule

bind ir_temp_qualify_average_alert irtq_checker u_irtq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// ===== test/ir_temp_qualify_average_alert_tb.sv =====
// testbench for ir_temp_qualify_average_alert: directed and random items with a
// scoreboard that predicts every result. depends on irtq_pkg and the block rtl
`timescale 1ns / 100ps

module ir_temp_qualify_average_alert_tb;
	import irtq_pkg::*;

	localparam int BURST_LEN = BURST_SAMPLES_DEF;
	localparam int CYCLE_LIMIT = 300000;

	class reading_tracker;
		logic [14:0] warn_lvl;
		logic [14:0] clear_lvl;
		logic [31:0] cool_ms;
		logic [14:0] lo_lim;
		logic [14:0] hi_lim;

		logic [14:0] obj_t;
		logic [14:0] amb_t;
		bit          seen;
		bit          alarm;
		logic [31:0] alarm_stamp;
		bit          collecting;
		logic [3:0]  n_taken;
		logic [17:0] acc;

		out_item_t expected_q[$];
		int failures;

		function new();
			warn_lvl = WARN_LEVEL_RST;
			clear_lvl = CLEAR_LEVEL_RST;
			cool_ms = COOLDOWN_RST;
			lo_lim = MIN_VALID_RST;
			hi_lim = MAX_VALID_RST;
			obj_t = '0;
			amb_t = '0;
			seen = 1'b0;
			alarm = 1'b0;
			alarm_stamp = '0;
			collecting = 1'b0;
			n_taken = '0;
			acc = '0;
			failures = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [31:0] val);
			case (idx)
				CFG_WARN_LEVEL: warn_lvl = val[14:0];
				CFG_CLEAR_LEVEL: clear_lvl = val[14:0];
				CFG_COOLDOWN: cool_ms = val;
				CFG_MIN_VALID: lo_lim = val[14:0];
				CFG_MAX_VALID: hi_lim = val[14:0];
				default: ;
			endcase
		endfunction

		function bit word_ok(logic [15:0] w);
			return !w[15] && w[14:0] >= lo_lim && w[14:0] <= hi_lim;
		endfunction

		function void update_alarm(logic [31:0] now, inout out_item_t res);
			logic [31:0] elapsed;
			elapsed = now - alarm_stamp;
			if (obj_t >= warn_lvl) begin
				if (!alarm || elapsed >= cool_ms) begin
					res.warn_event = 1'b1;
					alarm_stamp = now;
					alarm = 1'b1;
				end
			end else if (obj_t < clear_lvl && alarm) begin
				res.normal_event = 1'b1;
				alarm = 1'b0;
				alarm_stamp = '0;
			end
		endfunction

		function void note_item(in_item_t item);
			out_item_t res;
			res = '0;
			if (item.command == CMD_BURST) begin
				if (!collecting) begin
					collecting = 1'b1;
					n_taken = '0;
					acc = '0;
				end
			end else if (collecting) begin
				if (word_ok(item.raw_object)) begin
					acc = acc + 18'(item.raw_object[14:0]);
					n_taken = n_taken + 4'd1;
				end else begin
					res.sample_rejected = 1'b1;
				end
				if (n_taken >= BURST_LEN) begin
					obj_t = 15'((acc + 18'(n_taken >> 1)) / 18'(n_taken));
					seen = 1'b1;
					collecting = 1'b0;
					n_taken = '0;
					acc = '0;
					res.burst_done = 1'b1;
					update_alarm(item.now_ms, res);
				end
			end else if (word_ok(item.raw_object) && word_ok(item.raw_ambient)) begin
				obj_t = item.raw_object[14:0];
				amb_t = item.raw_ambient[14:0];
				seen = 1'b1;
				update_alarm(item.now_ms, res);
			end else begin
				res.sample_rejected = 1'b1;
			end
			res.object_temp = obj_t;
			res.ambient_temp = amb_t;
			res.has_data = seen;
			res.alert_on = alarm;
			res.burst_busy = collecting;
			expected_q.push_back(res);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				failures++;
				$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (expected_q.size() == 0) begin
				failures++;
				$display("%0t: result with no item pending, got %h", $time, got);
				return;
			end
			want = expected_q.pop_front();
			compare_field("object_temp", 32'(want.object_temp), 32'(got.object_temp));
			compare_field("ambient_temp", 32'(want.ambient_temp), 32'(got.ambient_temp));
			compare_field("has_data", 32'(want.has_data), 32'(got.has_data));
			compare_field("sample_rejected", 32'(want.sample_rejected),
				32'(got.sample_rejected));
			compare_field("warn_event", 32'(want.warn_event), 32'(got.warn_event));
			compare_field("normal_event", 32'(want.normal_event), 32'(got.normal_event));
			compare_field("alert_on", 32'(want.alert_on), 32'(got.alert_on));
			compare_field("burst_busy", 32'(want.burst_busy), 32'(got.burst_busy));
			compare_field("burst_done", 32'(want.burst_done), 32'(got.burst_done));
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [CfgAddrW-1:0] cfg_addr = '0;
	logic [CfgW-1:0]     cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_data;

	reading_tracker sb = new();
	bit          gaps_on = 1'b1;
	logic [31:0] clock_ms = '0;
	int          cycle_count = 0;

	ir_temp_qualify_average_alert #(
		.BurstSamples(BURST_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(negedge clk) begin
		out_ready <= !gaps_on || ($urandom_range(99) >= 36);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_item(in_data);
			if (out_valid && out_ready)
				sb.check_result(out_data);
		end
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("ir_temp_qualify_average_alert_tb: FAIL");
			$finish;
		end
	end

	task automatic send_item(in_item_t item);
		while (gaps_on && $urandom_range(99) < 36) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do begin
			@(posedge clk);
		end while (!in_ready);
		@(negedge clk);
	endtask

	task automatic send_fields(cmd_t cmd, logic [15:0] obj, logic [15:0] amb,
			logic [31:0] stamp);
		in_item_t item;
		item.command = cmd;
		item.raw_object = obj;
		item.raw_ambient = amb;
		item.now_ms = stamp;
		send_item(item);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic put_reg(cfg_idx_t idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		sb.set_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic load_config(logic [14:0] warn, logic [14:0] clear, logic [31:0] cool,
			logic [14:0] lo, logic [14:0] hi);
		put_reg(CFG_WARN_LEVEL, {17'd0, warn});
		put_reg(CFG_CLEAR_LEVEL, {17'd0, clear});
		put_reg(CFG_COOLDOWN, cool);
		put_reg(CFG_MIN_VALID, {17'd0, lo});
		put_reg(CFG_MAX_VALID, {17'd0, hi});
		cfg_we <= 1'b0;
	endtask

	task automatic rand_config();
		int lo;
		int hi;
		int clear;
		int warn;
		logic [31:0] cool;
		lo = $urandom_range(16000);
		hi = $urandom_range(32767, lo + 1000);
		clear = $urandom_range(hi, lo);
		warn = $urandom_range(hi, clear);
		// occasionally let the levels cross
		if ($urandom_range(2) == 0)
			warn = $urandom_range(hi, lo);
		cool = ($urandom_range(3) == 0) ? $urandom : $urandom_range(100000);
		load_config(15'(warn), 15'(clear), cool, 15'(lo), 15'(hi));
	endtask

	function automatic logic [31:0] next_stamp();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 5)
			clock_ms = $urandom;
		else if (sel < 55)
			clock_ms = clock_ms + $urandom_range(2000);
		else if (sel < 90)
			clock_ms = clock_ms + sb.cool_ms + $urandom_range(4) - 2;
		else
			clock_ms = clock_ms + $urandom;
		return clock_ms;
	endfunction

	function automatic logic [14:0] pick_temp();
		int unsigned sel;
		int v;
		sel = $urandom_range(99);
		if (sel < 30)
			v = int'(sb.warn_lvl) + int'($urandom_range(6)) - 3;
		else if (sel < 55)
			v = int'(sb.clear_lvl) + int'($urandom_range(6)) - 3;
		else if (sel < 65)
			v = ($urandom_range(1) ? int'(sb.lo_lim) : int'(sb.hi_lim))
				+ int'($urandom_range(2)) - 1;
		else if (sel < 90)
			v = $urandom_range(sb.hi_lim, sb.lo_lim);
		else
			v = $urandom_range(32767);
		return 15'(v);
	endfunction

	function automatic logic [15:0] pick_word();
		if ($urandom_range(99) < 6)
			return {1'b1, 15'($urandom)};
		return {1'b0, pick_temp()};
	endfunction

	function automatic logic [15:0] pick_ambient();
		if ($urandom_range(99) < 85)
			return {1'b0, 15'($urandom_range(sb.hi_lim, sb.lo_lim))};
		return pick_word();
	endfunction

	task automatic run_phase(int n_items);
		int sent;
		int sel;
		int len;
		sent = 0;
		while (sent < n_items) begin
			sel = $urandom_range(99);
			if (sel < 62) begin
				send_fields(CMD_SAMPLE, pick_word(), pick_ambient(), next_stamp());
				sent++;
			end else if (sel < 82) begin
				send_fields(CMD_BURST, 16'($urandom), 16'($urandom), next_stamp());
				len = BURST_LEN + $urandom_range(3);
				repeat (len)
					send_fields(CMD_SAMPLE, pick_word(), 16'($urandom), next_stamp());
				sent += len + 1;
			end else begin
				send_fields(cmd_t'($urandom_range(1)), 16'($urandom), 16'($urandom),
					$urandom);
				sent++;
			end
		end
		settle();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// qualification edges at reset levels
		send_fields(CMD_SAMPLE, 16'h8000 | 16'd20000, 16'd15000, 32'd10);
		send_fields(CMD_SAMPLE, 16'd15000, 16'hFFFF, 32'd20);
		send_fields(CMD_SAMPLE, 16'd11657, 16'd15000, 32'd30);
		send_fields(CMD_SAMPLE, 16'd32658, 16'd15000, 32'd40);
		send_fields(CMD_SAMPLE, 16'h7FFF, 16'h0000, 32'd50);
		send_fields(CMD_SAMPLE, 16'd11658, 16'd32657, 32'd60);
		// first warning, cooldown edge, hysteresis
		send_fields(CMD_SAMPLE, 16'd32657, 16'd11658, 32'd1000);
		send_fields(CMD_SAMPLE, 16'd16658, 16'd15000, 32'd60999);
		send_fields(CMD_SAMPLE, 16'd16658, 16'd15000, 32'd61000);
		send_fields(CMD_SAMPLE, 16'd16408, 16'd15000, 32'd61100);
		send_fields(CMD_SAMPLE, 16'd16407, 16'd15000, 32'd61200);
		// cooldown across stamp wrap
		send_fields(CMD_SAMPLE, 16'd16658, 16'd15000, 32'hFFFF_FF00);
		send_fields(CMD_SAMPLE, 16'd20000, 16'd15000, 32'h0000_EA00);
		// burst with a repeated request, a rejected word and a half-way average
		send_fields(CMD_BURST, 16'hFFFF, 16'hFFFF, 32'h0000_EA01);
		send_fields(CMD_BURST, 16'h0000, 16'h0000, 32'h0000_EA02);
		send_fields(CMD_SAMPLE, 16'd16658, 16'hFFFF, 32'h0000_EA03);
		send_fields(CMD_SAMPLE, 16'd16659, 16'h0000, 32'h0000_EA04);
		send_fields(CMD_SAMPLE, 16'd16658, 16'd15000, 32'h0000_EA05);
		send_fields(CMD_SAMPLE, 16'd16659, 16'd15000, 32'h0000_EA06);
		send_fields(CMD_SAMPLE, 16'h8000 | 16'd16660, 16'd15000, 32'h0000_EA07);
		send_fields(CMD_SAMPLE, 16'd16658, 16'd15000, 32'h0000_EA08);
		send_fields(CMD_SAMPLE, 16'd16659, 16'd15000, 32'h0000_EA09);
		send_fields(CMD_SAMPLE, 16'd16658, 16'd15000, 32'h0000_EA0A);
		send_fields(CMD_SAMPLE, 16'd16659, 16'd15000, 32'h0000_EA0B);
		send_fields(CMD_SAMPLE, 16'd0, 16'd0, 32'hFFFF_FFFF);
		settle();

		load_config(WARN_LEVEL_RST, CLEAR_LEVEL_RST, COOLDOWN_RST, MIN_VALID_RST,
			MAX_VALID_RST);
		run_phase(400);

		// low extremes: every clean word valid, warning on every stored value
		load_config(15'd0, 15'd0, 32'd0, 15'd0, 15'h7FFF);
		run_phase(200);

		// high extremes: only the top value is valid
		load_config(15'h7FFF, 15'h7FFF, 32'hFFFF_FFFF, 15'h7FFF, 15'h7FFF);
		run_phase(150);

		// inverted range rejects every word
		load_config(15'd16658, 15'd16408, 32'd1000, 15'd20000, 15'd10000);
		run_phase(100);

		gaps_on = 1'b0;
		rand_config();
		run_phase(400);
		gaps_on = 1'b1;

		repeat (3) begin
			rand_config();
			run_phase(150);
		end

		repeat (4) @(negedge clk);
		if (sb.failures == 0 && sb.expected_q.size() == 0)
			$display("ir_temp_qualify_average_alert_tb: PASS");
		else
			$display("ir_temp_qualify_average_alert_tb: FAIL");
		$finish;
	end

endmodule
